// ===== design/grey_wolf_optimizer_step_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grey wolf optimizer step unit
// Implication checks, same-cycle and next-cycle, on clk_i with reset masked.
// ----------------------------------------------------------------------------
`ifndef GREY_WOLF_OPTIMIZER_STEP_UNIT_MACROS_SVH
`define GREY_WOLF_OPTIMIZER_STEP_UNIT_MACROS_SVH

// Hold cons in the same cycle as ante.
`define GWO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Hold cons in the cycle after ante.
`define GWO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gwo_pkg.sv =====
// ----------------------------------------------------------------------------
// Grey wolf optimizer package
// Sequencer states, operation codes, register indexes and datapath constants.
// ----------------------------------------------------------------------------
`default_nettype none

package gwo_pkg;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_FIT      = 12'b0000_0000_0010,
    ST_LOAD_END = 12'b0000_0000_0100,
    ST_RANK_INS = 12'b0000_0000_1000,
    ST_RANK_END = 12'b0000_0001_0000,
    ST_UPD_CUR  = 12'b0000_0010_0000,
    ST_DIV      = 12'b0000_0100_0000,
    ST_UPD_A    = 12'b0000_1000_0000,
    ST_LEAD     = 12'b0001_0000_0000,
    ST_UPD_NX   = 12'b0010_0000_0000,
    ST_UPD_NY   = 12'b0100_0000_0000,
    ST_UPD_CMP  = 12'b1000_0000_0000
  } gwo_state_e;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_RANK   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [1:0] CFG_POPULATION = 2'd0;
  localparam logic [1:0] CFG_ITER_LIMIT = 2'd1;
  localparam logic [1:0] CFG_POS_LIMIT  = 2'd2;

  localparam logic [3:0]  POP_RESET      = 4'd5;
  localparam logic [15:0] ITER_LIM_RESET = 16'd200;
  localparam logic [14:0] POS_LIM_RESET  = 15'd20480;

  // Divider: 34-bit dividend, 16-bit divisor, one quotient bit per cycle.
  localparam int unsigned DIV_W     = 34;
  localparam logic [5:0]  DIV_LAST  = 6'd33;
  localparam logic [17:0] A_ONE     = 18'd131072;
  // ceil(2^17 / 3): exact floor of m / 3 for any m below 2^17
  localparam logic [15:0] THIRD_RECIP = 16'd43691;
  localparam logic signed [31:0] FIT_INF = 32'sh7fff_ffff;

endpackage

`default_nettype wire

// ===== design/grey_wolf_optimizer_step_unit.sv =====
// ----------------------------------------------------------------------------
// Grey wolf optimizer step unit
// Load runs the fitness steps once, rank once per wolf in use, and update
// uses one restoring divider run for a and the shared 20x20 multiplier for
// the rest; rejected or unused ops answer straight from idle.
// One item at a time; busy_o stays high until the result beat goes out.
// Async active-low reset: control and result registers at reset values, leaders at (0,0).
// ----------------------------------------------------------------------------
`default_nettype none

`include "grey_wolf_optimizer_step_unit_macros.svh"

module grey_wolf_optimizer_step_unit
  import gwo_pkg::*;
#(
  parameter int MAX_WOLVES      = 8,
  parameter int COORD_FRAC_BITS = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [2:0]         wolf_index_i,
  input  wire logic signed [15:0] load_x_i,
  input  wire logic signed [15:0] load_y_i,
  input  wire logic [15:0]        iteration_number_i,
  input  wire logic [15:0]        rand_c_first_i,
  input  wire logic [15:0]        rand_c_second_i,
  input  wire logic [15:0]        rand_c_third_i,
  input  wire logic [15:0]        rand_a_first_i,
  input  wire logic [15:0]        rand_a_second_i,
  input  wire logic [15:0]        rand_a_third_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic [2:0]              result_wolf_index_o,
  output logic [2:0]              second_best_index_o,
  output logic [2:0]              third_best_index_o,
  output logic signed [15:0]      result_x_o,
  output logic signed [15:0]      result_y_o,
  output logic signed [31:0]      result_fitness_o,
  output logic                    position_replaced_o
);

  localparam int WIDX = $clog2(MAX_WOLVES);
  localparam logic signed [33:0] FIT_BIAS = 34'sd3 <<< COORD_FRAC_BITS;

  // Control state
  gwo_state_e state_q, ret_q;
  logic [1:0]      op_q;
  logic [2:0]      w_q;
  logic [1:0]      fstep_q;
  logic [2:0]      lstep_q;
  logic [1:0]      lk_q;
  logic [5:0]      div_cnt_q;
  logic [WIDX-1:0] ri_q, last_q;
  logic [3:0]      pop_q;
  logic [15:0]     ilim_q;
  logic [14:0]     plim_q;

  // Leader slots: ranking fills them, update reads them
  logic [WIDX-1:0]    slot_i_q [3];
  logic signed [15:0] slot_x_q [3];
  logic signed [15:0] slot_y_q [3];
  logic signed [31:0] slot_f_q [3];

  // Result beat
  logic               result_valid_q;
  logic [2:0]         res_idx0_q, res_idx1_q, res_idx2_q;
  logic signed [15:0] res_x_q, res_y_q;
  logic signed [31:0] res_fit_q;
  logic               res_repl_q;

  // Datapath
  logic [31:0]        wolf_mem_q [MAX_WOLVES];
  logic signed [15:0] fx_q, fy_q, wx_q, wy_q;
  logic signed [19:0] mul_a_q, mul_b_q;
  logic signed [33:0] acc_q;
  logic signed [31:0] fit_q, fo_q;
  logic [DIV_W-1:0]   div_dvd_q;
  logic [16:0]        div_rem_q;
  logic [15:0]        div_dsr_q;
  logic [17:0]        a_q;
  logic signed [18:0] big_a_q;
  logic [17:0]        d_x_q, d_y_q;
  logic signed [17:0] sx_q, sy_q;
  logic [15:0]        it_q;
  logic [15:0]        rc_q [3];
  logic [15:0]        ra_q [3];

  logic accept;
  logic w_valid;
  logic [WIDX-1:0] widx;
  logic [WIDX-1:0] last_d;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign w_valid     = (int'(wolf_index_i) < MAX_WOLVES);
  assign widx        = WIDX'(wolf_index_i);

  // Clamp population to [3, MAX_WOLVES]; keep the last index walked
  always_comb begin
    if (pop_q < 4'd3) begin
      last_d = WIDX'(2);
    end else if (int'(pop_q) > MAX_WOLVES) begin
      last_d = WIDX'(MAX_WOLVES - 1);
    end else begin
      last_d = WIDX'(pop_q - 4'd1);
    end
  end

  // Shared multiplier, fed only from registers
  logic signed [39:0] prod;
  logic signed [39:0] prod_sh16;
  assign prod      = mul_a_q * mul_b_q;
  assign prod_sh16 = prod >>> 16;

  // Fitness finish: floor shift of the quadratic plus the linear terms
  logic signed [33:0] quad;
  logic signed [33:0] fsum;
  assign quad = acc_q + prod[33:0];
  assign fsum = (quad >>> COORD_FRAC_BITS)
              + {{17{fx_q[15]}}, fx_q, 1'b0}
              + {{16{fy_q[15]}}, fy_q, 2'b0}
              + FIT_BIAS;

  // Leader arithmetic: A, D = |C*L - x| and the clamped candidate
  logic signed [39:0] big_a_full;
  logic signed [39:0] dev;
  logic signed [39:0] dev_abs;
  logic signed [15:0] lead_sel;
  logic signed [39:0] cand;
  logic signed [39:0] lim_ext;
  logic signed [15:0] cand_clamped;
  logic signed [15:0] w_sel;

  assign big_a_full = (prod >>> 15) - $signed({22'b0, a_q});
  assign w_sel      = (lstep_q == 3'd2) ? wx_q : wy_q;
  assign dev        = prod_sh16 - $signed({{24{w_sel[15]}}, w_sel});
  assign dev_abs    = dev[39] ? -dev : dev;
  assign lead_sel   = (lstep_q == 3'd4) ? slot_x_q[lk_q] : slot_y_q[lk_q];
  assign cand       = $signed({{24{lead_sel[15]}}, lead_sel}) - prod_sh16;
  assign lim_ext    = $signed({25'b0, plim_q});

  always_comb begin
    if (cand > lim_ext) begin
      cand_clamped = lim_ext[15:0];
    end else if (cand < -lim_ext) begin
      cand_clamped = 16'(-lim_ext);
    end else begin
      cand_clamped = cand[15:0];
    end
  end

  // Restoring divider step
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [16:0] rem_next;
  assign rem_sh   = {div_rem_q[15:0], div_dvd_q[DIV_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_dsr_q});
  assign rem_next = rem_ge ? (rem_sh - {1'b0, div_dsr_q}) : rem_sh;

  // Coefficient a setup: saturate the iteration at the (nonzero) limit
  logic [15:0] lim_eff;
  logic [15:0] it_sat;
  assign lim_eff = (ilim_q == 16'd0) ? 16'd1 : ilim_q;
  assign it_sat  = (it_q > lim_eff) ? lim_eff : it_q;

  // Floor division by three on sign and magnitude, by reciprocal multiply
  logic signed [17:0] mag_sx;
  logic signed [17:0] mag_sy;
  logic signed [15:0] q_signed;
  logic        q_neg;
  assign mag_sx   = sx_q[17] ? (-sx_q + 18'sd2) : sx_q;
  assign mag_sy   = sy_q[17] ? (-sy_q + 18'sd2) : sy_q;
  assign q_neg    = (state_q == ST_UPD_NX) ? sx_q[17] : sy_q[17];
  assign q_signed = q_neg ? -$signed(prod[32:17]) : $signed(prod[32:17]);

  logic keep;
  assign keep = (fit_q < fo_q);

  // Memory port control
  logic            rd_en;
  logic [WIDX-1:0] rd_addr;
  logic            wr_en;
  logic [WIDX-1:0] wr_addr;
  logic [31:0]     wr_data;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = widx;
    wr_en   = 1'b0;
    wr_addr = widx;
    wr_data = {load_x_i, load_y_i};
    unique case (state_q)
      ST_IDLE: begin
        if (accept && op_i == OP_RANK) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end else if (accept && op_i == OP_UPDATE && w_valid) begin
          rd_en = 1'b1;
        end else if (accept && op_i == OP_LOAD && w_valid) begin
          wr_en = 1'b1;
        end
      end
      ST_RANK_INS: begin
        rd_en   = (ri_q != last_q);
        rd_addr = ri_q + WIDX'(1);
      end
      ST_UPD_CMP: begin
        wr_en   = keep;
        wr_addr = WIDX'(w_q);
        wr_data = {fx_q, fy_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wolf_mem_q[wr_addr] <= wr_data;
    end
  end

  // Sequencer, configuration, leader slots and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      ret_q          <= ST_IDLE;
      op_q           <= OP_LOAD;
      w_q            <= '0;
      fstep_q        <= '0;
      lstep_q        <= '0;
      lk_q           <= '0;
      div_cnt_q      <= '0;
      ri_q           <= '0;
      last_q         <= '0;
      pop_q          <= POP_RESET;
      ilim_q         <= ITER_LIM_RESET;
      plim_q         <= POS_LIM_RESET;
      result_valid_q <= 1'b0;
      res_idx0_q     <= '0;
      res_idx1_q     <= '0;
      res_idx2_q     <= '0;
      res_x_q        <= '0;
      res_y_q        <= '0;
      res_fit_q      <= '0;
      res_repl_q     <= 1'b0;
      for (int s = 0; s < 3; s++) begin
        slot_i_q[s] <= '0;
        slot_x_q[s] <= '0;
        slot_y_q[s] <= '0;
        slot_f_q[s] <= '0;
      end
    end else begin
      result_valid_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_POPULATION: pop_q  <= cfg_data_i[3:0];
          CFG_ITER_LIMIT: ilim_q <= cfg_data_i;
          CFG_POS_LIMIT:  plim_q <= cfg_data_i[14:0];
          default: begin
          end
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= op_i;
            w_q     <= wolf_index_i;
            fstep_q <= '0;
            priority if (op_i == OP_RANK) begin
              ri_q    <= '0;
              last_q  <= last_d;
              ret_q   <= ST_RANK_INS;
              state_q <= ST_FIT;
              for (int s = 0; s < 3; s++) begin
                slot_f_q[s] <= FIT_INF;
              end
            end else if (op_i == OP_LOAD && w_valid) begin
              ret_q   <= ST_LOAD_END;
              state_q <= ST_FIT;
            end else if (op_i == OP_UPDATE && w_valid) begin
              ret_q   <= ST_UPD_CUR;
              state_q <= ST_FIT;
            end else begin
              // Out-of-range wolf or unused op: answer at once
              result_valid_q <= 1'b1;
              res_idx0_q     <= (op_i == OP_LOAD || op_i == OP_UPDATE) ? wolf_index_i : 3'd0;
              res_idx1_q     <= '0;
              res_idx2_q     <= '0;
              res_x_q        <= '0;
              res_y_q        <= '0;
              res_fit_q      <= '0;
              res_repl_q     <= 1'b0;
            end
          end
        end
        ST_FIT: begin
          fstep_q <= fstep_q + 2'd1;
          if (fstep_q == 2'd3) begin
            state_q <= ret_q;
          end
        end
        ST_LOAD_END: begin
          result_valid_q <= 1'b1;
          res_idx0_q     <= w_q;
          res_idx1_q     <= '0;
          res_idx2_q     <= '0;
          res_x_q        <= fx_q;
          res_y_q        <= fy_q;
          res_fit_q      <= fit_q;
          res_repl_q     <= 1'b0;
          state_q        <= ST_IDLE;
        end
        ST_RANK_INS: begin
          // Stable insertion: strict compare keeps the lower index on ties
          priority if (fit_q < slot_f_q[0]) begin
            slot_i_q[2] <= slot_i_q[1];
            slot_x_q[2] <= slot_x_q[1];
            slot_y_q[2] <= slot_y_q[1];
            slot_f_q[2] <= slot_f_q[1];
            slot_i_q[1] <= slot_i_q[0];
            slot_x_q[1] <= slot_x_q[0];
            slot_y_q[1] <= slot_y_q[0];
            slot_f_q[1] <= slot_f_q[0];
            slot_i_q[0] <= ri_q;
            slot_x_q[0] <= fx_q;
            slot_y_q[0] <= fy_q;
            slot_f_q[0] <= fit_q;
          end else if (fit_q < slot_f_q[1]) begin
            slot_i_q[2] <= slot_i_q[1];
            slot_x_q[2] <= slot_x_q[1];
            slot_y_q[2] <= slot_y_q[1];
            slot_f_q[2] <= slot_f_q[1];
            slot_i_q[1] <= ri_q;
            slot_x_q[1] <= fx_q;
            slot_y_q[1] <= fy_q;
            slot_f_q[1] <= fit_q;
          end else if (fit_q < slot_f_q[2]) begin
            slot_i_q[2] <= ri_q;
            slot_x_q[2] <= fx_q;
            slot_y_q[2] <= fy_q;
            slot_f_q[2] <= fit_q;
          end else begin
          end
          if (ri_q == last_q) begin
            state_q <= ST_RANK_END;
          end else begin
            ri_q    <= ri_q + WIDX'(1);
            fstep_q <= '0;
            state_q <= ST_FIT;
          end
        end
        ST_RANK_END: begin
          result_valid_q <= 1'b1;
          res_idx0_q     <= 3'(slot_i_q[0]);
          res_idx1_q     <= 3'(slot_i_q[1]);
          res_idx2_q     <= 3'(slot_i_q[2]);
          res_x_q        <= slot_x_q[0];
          res_y_q        <= slot_y_q[0];
          res_fit_q      <= slot_f_q[0];
          res_repl_q     <= 1'b0;
          state_q        <= ST_IDLE;
        end
        ST_UPD_CUR: begin
          div_cnt_q <= '0;
          ret_q     <= ST_UPD_A;
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == DIV_LAST) begin
            state_q <= ret_q;
          end
        end
        ST_UPD_A: begin
          lk_q    <= '0;
          lstep_q <= '0;
          state_q <= ST_LEAD;
        end
        ST_LEAD: begin
          if (lstep_q == 3'd5) begin
            lstep_q <= '0;
            if (lk_q == 2'd2) begin
              state_q <= ST_UPD_NX;
            end else begin
              lk_q <= lk_q + 2'd1;
            end
          end else begin
            lstep_q <= lstep_q + 3'd1;
          end
        end
        ST_UPD_NX: begin
          state_q <= ST_UPD_NY;
        end
        ST_UPD_NY: begin
          fstep_q <= '0;
          ret_q   <= ST_UPD_CMP;
          state_q <= ST_FIT;
        end
        ST_UPD_CMP: begin
          // Keep the move only on a strict fitness drop
          result_valid_q <= 1'b1;
          res_idx0_q     <= w_q;
          res_idx1_q     <= '0;
          res_idx2_q     <= '0;
          res_x_q        <= keep ? fx_q : wx_q;
          res_y_q        <= keep ? fy_q : wy_q;
          res_fit_q      <= keep ? fit_q : fo_q;
          res_repl_q     <= keep;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          it_q  <= iteration_number_i;
          rc_q[0] <= rand_c_first_i;
          rc_q[1] <= rand_c_second_i;
          rc_q[2] <= rand_c_third_i;
          ra_q[0] <= rand_a_first_i;
          ra_q[1] <= rand_a_second_i;
          ra_q[2] <= rand_a_third_i;
        end
        if (rd_en) begin
          {fx_q, fy_q} <= wolf_mem_q[rd_addr];
        end else if (accept && op_i == OP_LOAD) begin
          fx_q <= load_x_i;
          fy_q <= load_y_i;
        end
      end
      ST_FIT: begin
        unique case (fstep_q)
          2'd0: begin
            mul_a_q <= {{4{fx_q[15]}}, fx_q};
            mul_b_q <= {{4{fx_q[15]}}, fx_q};
          end
          2'd1: begin
            acc_q   <= prod[33:0];
            mul_b_q <= {{4{fy_q[15]}}, fy_q};
          end
          2'd2: begin
            acc_q   <= acc_q - prod[33:0];
            mul_a_q <= {{4{fy_q[15]}}, fy_q};
          end
          2'd3: begin
            fit_q <= fsum[31:0];
          end
          default: begin
          end
        endcase
      end
      ST_RANK_INS: begin
        if (rd_en) begin
          {fx_q, fy_q} <= wolf_mem_q[rd_addr];
        end
      end
      ST_UPD_CUR: begin
        fo_q      <= fit_q;
        wx_q      <= fx_q;
        wy_q      <= fy_q;
        div_dvd_q <= {1'b0, it_sat, 17'b0};
        div_rem_q <= '0;
        div_dsr_q <= lim_eff;
      end
      ST_DIV: begin
        div_rem_q <= rem_next;
        div_dvd_q <= {div_dvd_q[DIV_W-2:0], rem_ge};
      end
      ST_UPD_A: begin
        a_q  <= A_ONE - div_dvd_q[17:0];
        sx_q <= '0;
        sy_q <= '0;
      end
      ST_LEAD: begin
        unique case (lstep_q)
          3'd0: begin
            mul_a_q <= {2'b0, a_q};
            mul_b_q <= {4'b0, ra_q[lk_q]};
          end
          3'd1: begin
            big_a_q <= big_a_full[18:0];
            mul_a_q <= {3'b0, rc_q[lk_q], 1'b0};
            mul_b_q <= {{4{slot_x_q[lk_q][15]}}, slot_x_q[lk_q]};
          end
          3'd2: begin
            d_x_q   <= dev_abs[17:0];
            mul_b_q <= {{4{slot_y_q[lk_q][15]}}, slot_y_q[lk_q]};
          end
          3'd3: begin
            d_y_q   <= dev_abs[17:0];
            mul_a_q <= {big_a_q[18], big_a_q};
            mul_b_q <= {2'b0, d_x_q};
          end
          3'd4: begin
            sx_q    <= sx_q + {{2{cand_clamped[15]}}, cand_clamped};
            mul_b_q <= {2'b0, d_y_q};
          end
          3'd5: begin
            sy_q <= sy_q + {{2{cand_clamped[15]}}, cand_clamped};
            // Start the x mean: magnitude of the sum times one third
            mul_a_q <= {2'b0, mag_sx};
            mul_b_q <= {4'b0, THIRD_RECIP};
          end
          default: begin
          end
        endcase
      end
      ST_UPD_NX: begin
        fx_q    <= q_signed;
        mul_a_q <= {2'b0, mag_sy};
      end
      ST_UPD_NY: begin
        fy_q <= q_signed;
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o      = result_valid_q;
  assign result_wolf_index_o = res_idx0_q;
  assign second_best_index_o = res_idx1_q;
  assign third_best_index_o  = res_idx2_q;
  assign result_x_o          = res_x_q;
  assign result_y_o          = res_y_q;
  assign result_fitness_o    = res_fit_q;
  assign position_replaced_o = res_repl_q;

  `GWO_ASSERT_IMP(a_strobe_idle, result_valid_q, state_q == ST_IDLE, "result beat while busy")
  `GWO_ASSERT_NXT(a_rank_busy, start_i && !busy_o && op_i == OP_RANK, busy_o, "rank not busy")
  `GWO_ASSERT_IMP(a_leaders_distinct, state_q == ST_RANK_END, slot_i_q[0] != slot_i_q[1] && slot_i_q[1] != slot_i_q[2] && slot_i_q[0] != slot_i_q[2], "leaders not distinct")
  `GWO_ASSERT_IMP(a_replace_update, result_valid_q && res_repl_q, op_q == OP_UPDATE, "replace flag outside update")

endmodule

`default_nettype wire
